FILE: sv/matrix_multiply_4x4_assert.svh
// assertion macros for the 4x4 matrix multiplier
// no dependencies; the including module supplies clk and rst
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MM4_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mm4_pkg.sv
// shared types and constants of the 4x4 matrix multiplier
// no dependencies
package mm4_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned SUM_W         = PROD_W + 2;
  localparam int unsigned DIM           = 4;
  localparam int unsigned IDX_W         = 2;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]  CNT_LAST = {CNT_W{1'b1}};

  // one product element travelling down the cell chain
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } token_t;

endpackage

FILE: sv/mm4_cell.sv
// one multiply-accumulate cell of the chain: holds column K of the left
// matrix and row K of the right matrix; depends on mm4_pkg
module mm4_cell #(
  parameter int unsigned K = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load_en,
  input  logic [mm4_pkg::IDX_W-1:0]           load_row,
  input  logic [mm4_pkg::IDX_W-1:0]           load_col,
  input  logic [mm4_pkg::DATA_W-1:0]          left_in,
  input  logic [mm4_pkg::DATA_W-1:0]          right_in,
  input  mm4_pkg::token_t                     tok_in,
  input  logic signed [mm4_pkg::SUM_W-1:0]    sum_in,
  output mm4_pkg::token_t                     tok_out,
  output logic signed [mm4_pkg::SUM_W-1:0]    sum_out,
  output logic                                active
);

  localparam logic [mm4_pkg::IDX_W-1:0] KIDX = K[mm4_pkg::IDX_W-1:0];

  logic [mm4_pkg::DATA_W-1:0]        lcol [mm4_pkg::DIM];
  logic [mm4_pkg::DATA_W-1:0]        rrow [mm4_pkg::DIM];
  logic signed [mm4_pkg::PROD_W-1:0] prod;
  logic signed [mm4_pkg::SUM_W-1:0]  sum_d;
  mm4_pkg::token_t                   tok_a;

  // element storage
  always_ff @(posedge clk) begin
    if (load_en && load_col == KIDX) begin
      lcol[load_row] <= left_in;
    end
    if (load_en && load_row == KIDX) begin
      rrow[load_col] <= right_in;
    end
  end

  // stage a: product, stage b: accumulate
  always_ff @(posedge clk) begin
    prod    <= $signed(lcol[tok_in.row]) * $signed(rrow[tok_in.col]);
    sum_d   <= sum_in;
    sum_out <= sum_d + {{(mm4_pkg::SUM_W - mm4_pkg::PROD_W){prod[mm4_pkg::PROD_W-1]}}, prod};
    if (rst) begin
      tok_a   <= '0;
      tok_out <= '0;
    end else begin
      tok_a   <= tok_in;
      tok_out <= tok_a;
    end
  end

  assign active = tok_a.valid | tok_out.valid;

endmodule

FILE: sv/mm4_out.sv
// output stage: fixed-point shift, saturation and result register
// depends on mm4_pkg
module mm4_out #(
  parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mm4_pkg::token_t                   tok_in,
  input  logic signed [mm4_pkg::SUM_W-1:0]  sum_in,
  output logic [mm4_pkg::DATA_W-1:0]        product_element,
  output logic [mm4_pkg::IDX_W-1:0]         row_index,
  output logic [mm4_pkg::IDX_W-1:0]         column_index,
  output logic                              last_of_matrix,
  output logic                              valid
);

  logic signed [mm4_pkg::SUM_W-1:0] shifted;
  logic                             fits;
  logic [mm4_pkg::DATA_W-1:0]       sat;

  always_comb begin
    shifted = sum_in >>> FRAC_BITS;
    // upper bits must be pure sign extension of the low word
    fits = (&shifted[mm4_pkg::SUM_W-1:mm4_pkg::DATA_W-1]) |
           ~(|shifted[mm4_pkg::SUM_W-1:mm4_pkg::DATA_W-1]);
    if (fits) begin
      sat = shifted[mm4_pkg::DATA_W-1:0];
    end else if (sum_in[mm4_pkg::SUM_W-1]) begin
      sat = mm4_pkg::SAT_MIN;
    end else begin
      sat = mm4_pkg::SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    product_element <= sat;
    row_index       <= tok_in.row;
    column_index    <= tok_in.col;
    last_of_matrix  <= tok_in.last;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= tok_in.valid;
    end
  end

endmodule

FILE: sv/matrix_multiply_4x4.sv
// top level of the 4x4 signed Q16.16 matrix multiplier
// depends on mm4_pkg, mm4_cell, mm4_out and matrix_multiply_4x4_assert.svh
//
// usage
//   input transactions: a transaction is taken at a rising edge with start high
//   and busy low. each one carries one left and one right element, both in
//   row-major order. the first fifteen transactions of a pair only load.
//   on the sixteenth, busy rises and the block streams the sixteen product
//   elements in row-major order, one per cycle, each marked by valid for
//   exactly one cycle, with row_index, column_index and last_of_matrix.
//   pipeline: a row of four multiply-accumulate cells, two stages each, plus
//   one saturation stage. busy is high from the cycle after the sixteenth
//   load up to the cycle before the last result.
//   the cells read their own element stores, which is why loading waits
//   until the last element leaves the chain.
//   reset: clears the load count, the issue logic and all valid flags.
//   element stores hold garbage until loaded.
//   the receiver cannot stall: each result is on the ports for one cycle.
module matrix_multiply_4x4 #(
  parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mm4_pkg::DATA_W-1:0]  left_element,
  input  logic [mm4_pkg::DATA_W-1:0]  right_element,
  output logic [mm4_pkg::DATA_W-1:0]  product_element,
  output logic [mm4_pkg::IDX_W-1:0]   row_index,
  output logic [mm4_pkg::IDX_W-1:0]   column_index,
  output logic                        last_of_matrix,
  output logic                        valid
);

`include "matrix_multiply_4x4_assert.svh"

  // slot of the next load transaction
  logic [mm4_pkg::CNT_W-1:0] load_count;
  // issue sequencer: walks the sixteen product elements into the chain
  logic                      issuing;
  logic [mm4_pkg::CNT_W-1:0] issue_cnt;
  logic                      accept;

  // token and partial sum links between neighboring cells
  mm4_pkg::token_t                  tok_chain [mm4_pkg::DIM+1];
  logic signed [mm4_pkg::SUM_W-1:0] sum_chain [mm4_pkg::DIM+1];
  logic [mm4_pkg::DIM-1:0]          cell_active;

  assign accept = start & ~busy;
  // stores stay locked while any element is still reading them
  assign busy   = issuing | (|cell_active);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      issuing    <= 1'b0;
      issue_cnt  <= '0;
    end else begin
      if (accept) begin
        load_count <= load_count + 1'b1;
        if (load_count == mm4_pkg::CNT_LAST) begin
          issuing   <= 1'b1;
          issue_cnt <= '0;
        end
      end
      if (issuing) begin
        issue_cnt <= issue_cnt + 1'b1;
        if (issue_cnt == mm4_pkg::CNT_LAST) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  // head of the chain: a fresh element with an empty sum
  always_comb begin
    tok_chain[0].valid = issuing;
    tok_chain[0].row   = issue_cnt[mm4_pkg::CNT_W-1:mm4_pkg::IDX_W];
    tok_chain[0].col   = issue_cnt[mm4_pkg::IDX_W-1:0];
    tok_chain[0].last  = (issue_cnt == mm4_pkg::CNT_LAST);
    sum_chain[0]       = '0;
  end

  // cell k adds left[row][k] * right[k][col]
  for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_cell
    mm4_cell #(
      .K(k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .load_en  (accept),
      .load_row (load_count[mm4_pkg::CNT_W-1:mm4_pkg::IDX_W]),
      .load_col (load_count[mm4_pkg::IDX_W-1:0]),
      .left_in  (left_element),
      .right_in (right_element),
      .tok_in   (tok_chain[k]),
      .sum_in   (sum_chain[k]),
      .tok_out  (tok_chain[k+1]),
      .sum_out  (sum_chain[k+1]),
      .active   (cell_active[k])
    );
  end

  mm4_out #(
    .FRAC_BITS(FRAC_BITS)
  ) u_out (
    .clk             (clk),
    .rst             (rst),
    .tok_in          (tok_chain[mm4_pkg::DIM]),
    .sum_in          (sum_chain[mm4_pkg::DIM]),
    .product_element (product_element),
    .row_index       (row_index),
    .column_index    (column_index),
    .last_of_matrix  (last_of_matrix),
    .valid           (valid)
  );

  // results of one matrix come out back to back
  `MM4_ASSERT_NEXT(a_burst_contiguous, valid && !last_of_matrix, valid, "gap in result burst")
  // a pair ends with exactly the bottom-right element
  `MM4_ASSERT_SAME(a_last_corner, valid && last_of_matrix, row_index == 2'd3 && column_index == 2'd3, "last flag off corner")
  // the sixteenth load locks the block
  `MM4_ASSERT_NEXT(a_lock_after_load, accept && load_count == mm4_pkg::CNT_LAST, busy && load_count == '0, "no lock after full load")
  // nothing follows the last result of a burst
  `MM4_ASSERT_NEXT(a_burst_end, valid && last_of_matrix, !valid, "result after last of matrix")

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the 4x4 signed Q16.16 matrix multiplier
// depends on mm4_pkg and matrix_multiply_4x4; predicts every product element and
// checks the streamed results in order
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FRAC       = mm4_pkg::FRAC_BITS_DEF;
  localparam int unsigned TIMEOUT_NS = 500_000;
  localparam int unsigned DRAIN_CYC  = 30;    // margin after the last expected element
  localparam int unsigned RAND_PAIRS = 26;    // 26 pairs of 16 loads after the directed pair
  localparam int unsigned MAX_REPORT = 10;

  // handy Q16.16 values
  localparam logic [mm4_pkg::DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [mm4_pkg::DATA_W-1:0] Q_LSB     = 32'h0000_0001;
  localparam logic [mm4_pkg::DATA_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;

  typedef logic [mm4_pkg::IDX_W-1:0] idx_t;

  // one expected product element
  typedef struct packed {
    logic [mm4_pkg::DATA_W-1:0] element;
    logic [mm4_pkg::IDX_W-1:0]  row;
    logic [mm4_pkg::IDX_W-1:0]  col;
    logic                       last;
  } product_elem_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [mm4_pkg::DATA_W-1:0] left_element = '0;
  logic [mm4_pkg::DATA_W-1:0] right_element = '0;
  logic                       busy;
  logic [mm4_pkg::DATA_W-1:0] product_element;
  logic [mm4_pkg::IDX_W-1:0]  row_index;
  logic [mm4_pkg::IDX_W-1:0]  column_index;
  logic                       last_of_matrix;
  logic                       valid;

  // shadow copy of the block's element stores and load slot
  logic [mm4_pkg::DATA_W-1:0] left_shadow [mm4_pkg::DIM*mm4_pkg::DIM];
  logic [mm4_pkg::DATA_W-1:0] right_shadow [mm4_pkg::DIM*mm4_pkg::DIM];
  logic [mm4_pkg::CNT_W-1:0]  load_slot = '0;

  product_elem_t     expected_products [$];
  product_elem_t     head_expected;

  int unsigned       fail_count = 0;
  int unsigned       loads_accepted = 0;
  int unsigned       elements_checked = 0;
  int unsigned       saturated_count = 0;
  int unsigned       pairs_done = 0;

  always #5 clk = ~clk;

  matrix_multiply_4x4 #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .left_element   (left_element),
    .right_element  (right_element),
    .product_element(product_element),
    .row_index      (row_index),
    .column_index   (column_index),
    .last_of_matrix (last_of_matrix),
    .valid          (valid)
  );

  // ---------------------------------------------------------------------------
  // failure bookkeeping: only the first few are printed in full
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: one product element from the shadow stores
  // exact sum of four 64-bit products in a 66-bit accumulator, arithmetic shift
  // (truncation toward minus infinity), then clamp to the signed 32-bit range
  // ---------------------------------------------------------------------------
  function automatic logic [mm4_pkg::DATA_W-1:0] dot_q16(int unsigned row,
                                                          int unsigned col,
                                                          output logic clamped);
    logic signed [mm4_pkg::PROD_W-1:0] term;
    logic signed [mm4_pkg::SUM_W-1:0]  acc;
    logic signed [mm4_pkg::SUM_W-1:0]  scaled;
    acc = '0;
    for (int unsigned k = 0; k < mm4_pkg::DIM; k++) begin
      term = $signed(left_shadow[row*mm4_pkg::DIM + k]) *
             $signed(right_shadow[k*mm4_pkg::DIM + col]);
      acc  = acc + term;
    end
    scaled = acc >>> FRAC;
    // fits when every bit from the sign of the 32-bit result upward agrees
    if ((&scaled[mm4_pkg::SUM_W-1:mm4_pkg::DATA_W-1]) ||
        !(|scaled[mm4_pkg::SUM_W-1:mm4_pkg::DATA_W-1])) begin
      clamped = 1'b0;
      return scaled[mm4_pkg::DATA_W-1:0];
    end
    clamped = 1'b1;
    return scaled[mm4_pkg::SUM_W-1] ? mm4_pkg::SAT_MIN : mm4_pkg::SAT_MAX;
  endfunction

  // record one accepted load; the sixteenth one queues the whole product matrix
  task automatic predict_load(input logic [mm4_pkg::DATA_W-1:0] l,
                              input logic [mm4_pkg::DATA_W-1:0] r);
    product_elem_t pe;
    logic          clamped;
    left_shadow[load_slot]  = l;
    right_shadow[load_slot] = r;
    loads_accepted++;
    if (load_slot == mm4_pkg::CNT_LAST) begin
      for (int unsigned row = 0; row < mm4_pkg::DIM; row++) begin
        for (int unsigned col = 0; col < mm4_pkg::DIM; col++) begin
          pe.element = dot_q16(row, col, clamped);
          pe.row     = idx_t'(row);
          pe.col     = idx_t'(col);
          pe.last    = (row == mm4_pkg::DIM - 1) && (col == mm4_pkg::DIM - 1);
          if (clamped) saturated_count++;
          expected_products.push_back(pe);
        end
      end
      pairs_done++;
    end
    load_slot = load_slot + 1'b1;   // wraps to the next pair
  endtask

  // ---------------------------------------------------------------------------
  // send one load transaction: random idle gap, then hold start until busy is
  // low at a rising edge; entered and left right after a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_element(input logic [mm4_pkg::DATA_W-1:0] l,
                              input logic [mm4_pkg::DATA_W-1:0] r,
                              input int unsigned max_gap);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    left_element  <= l;
    right_element <= r;
    // busy read here is the value in force during the cycle that just ended
    do begin
      @(posedge clk);
    end while (busy);
    predict_load(l, r);
  endtask

  // mostly modest magnitudes so sums stay in range, plus extremes and full words
  function automatic logic [mm4_pkg::DATA_W-1:0] rand_element();
    logic [mm4_pkg::DATA_W-1:0] raw;
    raw = $urandom;
    case ($urandom_range(9, 0))
      0:       return mm4_pkg::SAT_MAX;
      1:       return mm4_pkg::SAT_MIN;
      2, 3, 4: return raw;
      5, 6:    return {{11{raw[20]}}, raw[20:0]};    // about +-16.0
      default: return {{15{raw[16]}}, raw[16:0]};    // about +-1.0
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: valid marks one element for exactly one cycle, no stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_products.size() == 0) begin
        note_failure($sformatf("unexpected element %h at (%0d,%0d) last=%b",
                               product_element, row_index, column_index, last_of_matrix));
      end else begin
        head_expected = expected_products.pop_front();
        elements_checked++;
        if (product_element !== head_expected.element || row_index !== head_expected.row ||
            column_index !== head_expected.col || last_of_matrix !== head_expected.last) begin
          note_failure($sformatf("exp %h (%0d,%0d) last=%b, got %h (%0d,%0d) last=%b",
                                 head_expected.element, head_expected.row, head_expected.col,
                                 head_expected.last, product_element, row_index,
                                 column_index, last_of_matrix));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed pair: each left row and each right column is one kind of value
  //   left rows:     max, min, minus one lsb, and 1.0 in the first column only
  //   right columns: max, min, one lsb, 1.0
  // gives positive and negative clamping, min*min, truncation of a tiny
  // negative sum to minus one lsb, and sums landing exactly on the limits
  // ---------------------------------------------------------------------------
  task automatic test_saturation_and_truncation();
    logic [mm4_pkg::DATA_W-1:0] l;
    logic [mm4_pkg::DATA_W-1:0] r;
    for (int unsigned i = 0; i < mm4_pkg::DIM*mm4_pkg::DIM; i++) begin
      case (i / mm4_pkg::DIM)
        0:       l = mm4_pkg::SAT_MAX;
        1:       l = mm4_pkg::SAT_MIN;
        2:       l = Q_NEG_LSB;
        default: l = (i % mm4_pkg::DIM == 0) ? Q_ONE : '0;
      endcase
      case (i % mm4_pkg::DIM)
        0:       r = mm4_pkg::SAT_MAX;
        1:       r = mm4_pkg::SAT_MIN;
        2:       r = Q_LSB;
        default: r = Q_ONE;
      endcase
      send_element(l, r, 4);
    end
  endtask

  // ---------------------------------------------------------------------------
  // random pairs back to back: loads of the next pair wait on busy, so the
  // load count wrap and the busy hold-off are hit on every pair; some pairs
  // run with no idle cycles at all
  // ---------------------------------------------------------------------------
  task automatic test_random_pairs();
    int unsigned max_gap;
    for (int unsigned p = 0; p < RAND_PAIRS; p++) begin
      max_gap = ($urandom_range(3, 0) == 0) ? 0 : 4;
      for (int unsigned i = 0; i < mm4_pkg::DIM*mm4_pkg::DIM; i++) begin
        send_element(rand_element(), rand_element(), max_gap);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_saturation_and_truncation();
    test_random_pairs();

    // everything is loaded; let the last matrix stream out
    start <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d load transactions in %0d matrix pairs", loads_accepted, pairs_done);
    $display("checked %0d product elements, %0d of them clamped, %0d failures",
             elements_checked, saturated_count, fail_count);
    if (fail_count == 0) begin
      $display("matrix_multiply_4x4 regression: pass");
    end else begin
      $display("matrix_multiply_4x4 regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d elements still expected", expected_products.size());
    $display("matrix_multiply_4x4 regression: fail");
    $finish;
  end

endmodule

FILE: matrix_multiply_4x4.f
+incdir+sv
sv/mm4_pkg.sv
sv/mm4_cell.sv
sv/mm4_out.sv
sv/matrix_multiply_4x4.sv
tb/tb_top.sv
